// ----- rtl/pafp_pkg.sv -----
// Package for the partition allocator: table entry type, opcodes, status codes,
// cell commands, sequencer states. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pafp_pkg;
    localparam int MaxParts  = 16;
    localparam int AddrWidth = 16;
    localparam int IdxWidth  = $clog2(MaxParts);
    localparam int CntWidth  = $clog2(MaxParts + 1);

    typedef logic [AddrWidth-1:0] t_addr;
    typedef logic [IdxWidth-1:0]  t_idx;
    typedef logic [CntWidth-1:0]  t_cnt;

    typedef struct packed {
        t_addr start;
        t_addr size;
        logic  alloc;
    } t_entry;

    typedef enum logic [1:0] {
        OP_FIRST = 2'd0,
        OP_BEST  = 2'd1,
        OP_WORST = 2'd2,
        OP_FREE  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NO_FIT  = 2'd1,
        ST_NOT_ALC = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    // per-cycle command to every cell
    typedef enum logic [2:0] {
        CC_HOLD,
        CC_INIT,
        CC_SPLIT,
        CC_MARK,
        CC_MERGE
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        t_idx     pos;
        t_addr    req;
        t_addr    msize;
        t_addr    merged;
    } t_cell_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_MNEXT,
        S_MPREV,
        S_DONE
    } t_state;
endpackage
`default_nettype wire

// ----- rtl/pafp_cell.sv -----
// One table slot of the partition allocator: holds an entry and can take its
// neighbor's entry to shift the table up (split) or down (merge). Uses pafp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pafp_cell (
    input  wire                 i_clk,
    input  wire pafp_pkg::t_idx i_my_idx,
    input  wire pafp_pkg::t_cell_cmd i_cmd,
    input  wire pafp_pkg::t_entry    i_lower,
    input  wire pafp_pkg::t_entry    i_upper,
    output pafp_pkg::t_entry    o_entry
);
    pafp_pkg::t_entry r_entry, n_entry;

    always_comb begin
        n_entry = r_entry;
        case (i_cmd.op)
            pafp_pkg::CC_INIT: begin
                n_entry.start = '0;
                n_entry.alloc = 1'b0;
                n_entry.size  = (i_my_idx == '0) ? i_cmd.msize : '0;
            end
            pafp_pkg::CC_SPLIT: begin
                if (i_my_idx == i_cmd.pos) begin
                    n_entry.size  = i_cmd.req;
                    n_entry.alloc = 1'b1;
                end else if (i_my_idx == i_cmd.pos + 1'b1) begin
                    n_entry.start = r_entry.start + i_cmd.req;
                    n_entry.size  = r_entry.size - i_cmd.req;
                    n_entry.alloc = 1'b0;
                    n_entry.start = i_lower.start + i_cmd.req;
                    n_entry.size  = i_lower.size - i_cmd.req;
                end else if (i_my_idx > i_cmd.pos + 1'b1) begin
                    n_entry = i_lower;
                end
            end
            pafp_pkg::CC_MARK: begin
                if (i_my_idx == i_cmd.pos) n_entry.alloc = ~r_entry.alloc;
            end
            pafp_pkg::CC_MERGE: begin
                if (i_my_idx == i_cmd.pos) begin
                    n_entry.size  = i_cmd.merged;
                    n_entry.alloc = 1'b0;
                end else if (i_my_idx > i_cmd.pos) begin
                    n_entry = i_upper;
                end
            end
            default: n_entry = r_entry;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;
endmodule
`default_nettype wire

// ----- rtl/partition_allocator_fit_policies.sv -----
// Top level of the partition allocator: sequencer plus a row of pafp_cell slots.
// Uses pafp_pkg and pafp_cell.
//
// Usage: pulse i_start with opcode, request size and free start while o_busy is
// low. One result beat (o_done high for one cycle) carries o_status and
// o_granted_start. The receiver cannot stall; results are never held.
// Allocate: from accept, the sequencer scans every valid table slot, then a
// decide step splits or marks the picked slot, then the result beat follows; a
// free that misses runs the same steps, and a free that hits adds two merge
// steps (merge with next, merge with previous) after the mark in decide.
// The next request is accepted in the cycle after the result beat, so requests
// never overlap.
// Reset (i_rst_n low, synchronous) sets memory size 65535 and re-forms the
// table into one free partition over the next cycle; i_cfg_we writes memory
// size and re-forms the table the same way. Write configuration only while
// idle.
`timescale 1ns / 1ps
`default_nettype none
module partition_allocator_fit_policies (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_we,
    input  wire [15:0] i_cfg_wdata,
    input  wire        i_start,
    input  wire [1:0]  i_opcode,
    input  wire [15:0] i_request_size,
    input  wire [15:0] i_free_start,
    output logic       o_busy,
    output logic       o_done,
    output logic [1:0] o_status,
    output logic [15:0] o_granted_start
);
    localparam int N = pafp_pkg::MaxParts;

    pafp_pkg::t_entry    w_ent [N];
    pafp_pkg::t_cell_cmd w_cmd;

    pafp_pkg::t_state r_state, n_state;
    pafp_pkg::t_addr  r_msize;
    logic             r_init;
    pafp_pkg::t_cnt   r_count, n_count;
    pafp_pkg::t_cnt   r_scan;
    logic [1:0]       r_op;
    pafp_pkg::t_addr  r_req, r_fstart;
    logic             r_found;
    pafp_pkg::t_idx   r_pick;
    pafp_pkg::t_addr  r_psize;
    logic [1:0]       r_status, n_status;
    pafp_pkg::t_addr  r_grant;

    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_cell
            pafp_pkg::t_entry w_lo, w_up;
            if (g == 0) begin : g_lo0
                assign w_lo = w_ent[0];
            end else begin : g_lo
                assign w_lo = w_ent[g-1];
            end
            if (g == N-1) begin : g_upN
                assign w_up = w_ent[N-1];
            end else begin : g_up
                assign w_up = w_ent[g+1];
            end
            pafp_cell u_cell (
                .i_clk    (i_clk),
                .i_my_idx (pafp_pkg::t_idx'(g)),
                .i_cmd    (w_cmd),
                .i_lower  (w_lo),
                .i_upper  (w_up),
                .o_entry  (w_ent[g])
            );
        end
    endgenerate

    pafp_pkg::t_idx   w_sidx;
    pafp_pkg::t_entry w_se, w_pe, w_ne, w_ve;
    logic             w_cand, w_take;
    logic             w_has_next, w_has_prev;
    assign w_sidx = r_scan[pafp_pkg::IdxWidth-1:0];
    assign w_se   = w_ent[w_sidx];
    assign w_pe   = w_ent[r_pick];
    assign w_ne   = w_ent[r_pick + 1'b1];
    assign w_ve   = w_ent[r_pick - 1'b1];
    assign w_has_next = ({1'b0, r_pick} + 1'b1) < r_count;
    assign w_has_prev = r_pick != '0;

    always_comb begin
        w_cand = 1'b0;
        w_take = 1'b0;
        if (r_op == pafp_pkg::OP_FREE) begin
            w_cand = w_se.alloc && w_se.start == r_fstart;
            w_take = w_cand && !r_found;
        end else begin
            w_cand = !w_se.alloc && w_se.size >= r_req;
            case (r_op)
                pafp_pkg::OP_BEST:  w_take = w_cand && (!r_found || w_se.size < r_psize);
                pafp_pkg::OP_WORST: w_take = w_cand && (!r_found || w_se.size > r_psize);
                default:            w_take = w_cand && !r_found;
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            pafp_pkg::S_IDLE: if (i_start && !r_init) n_state = pafp_pkg::S_SCAN;
            pafp_pkg::S_SCAN: if (r_scan + 1'b1 >= r_count) n_state = pafp_pkg::S_DECIDE;
            pafp_pkg::S_DECIDE:
                n_state = (r_op == pafp_pkg::OP_FREE && r_found) ? pafp_pkg::S_MNEXT
                                                                 : pafp_pkg::S_DONE;
            pafp_pkg::S_MNEXT: n_state = pafp_pkg::S_MPREV;
            pafp_pkg::S_MPREV: n_state = pafp_pkg::S_DONE;
            pafp_pkg::S_DONE:  n_state = pafp_pkg::S_IDLE;
            default:           n_state = pafp_pkg::S_IDLE;
        endcase
    end

    // cell commands and status
    always_comb begin
        w_cmd.op     = pafp_pkg::CC_HOLD;
        w_cmd.pos    = r_pick;
        w_cmd.req    = r_req;
        w_cmd.msize  = r_msize;
        w_cmd.merged = '0;
        n_count  = r_count;
        n_status = r_status;
        case (r_state)
            pafp_pkg::S_IDLE: begin
                if (r_init) begin
                    w_cmd.op = pafp_pkg::CC_INIT;
                    n_count  = pafp_pkg::t_cnt'(1);
                end
            end
            pafp_pkg::S_DECIDE: begin
                if (r_op == pafp_pkg::OP_FREE) begin
                    if (r_found) begin
                        w_cmd.op = pafp_pkg::CC_MARK;
                        n_status = pafp_pkg::ST_OK;
                    end else begin
                        n_status = pafp_pkg::ST_NOT_ALC;
                    end
                end else if (r_req == '0) begin
                    n_status = pafp_pkg::ST_FULL;
                end else if (!r_found) begin
                    n_status = pafp_pkg::ST_NO_FIT;
                end else if (r_psize == r_req) begin
                    w_cmd.op = pafp_pkg::CC_MARK;
                    n_status = pafp_pkg::ST_OK;
                end else if (r_count >= pafp_pkg::t_cnt'(N)) begin
                    n_status = pafp_pkg::ST_FULL;
                end else begin
                    w_cmd.op = pafp_pkg::CC_SPLIT;
                    n_count  = r_count + 1'b1;
                    n_status = pafp_pkg::ST_OK;
                end
            end
            pafp_pkg::S_MNEXT: begin
                if (w_has_next && !w_ne.alloc) begin
                    w_cmd.op     = pafp_pkg::CC_MERGE;
                    w_cmd.pos    = r_pick;
                    w_cmd.merged = w_pe.size + w_ne.size;
                    n_count      = r_count - 1'b1;
                end
            end
            pafp_pkg::S_MPREV: begin
                if (w_has_prev && !w_ve.alloc) begin
                    w_cmd.op     = pafp_pkg::CC_MERGE;
                    w_cmd.pos    = r_pick - 1'b1;
                    w_cmd.merged = w_ve.size + w_pe.size;
                    n_count      = r_count - 1'b1;
                end
            end
            default: w_cmd.op = pafp_pkg::CC_HOLD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= pafp_pkg::S_IDLE;
            r_msize  <= 16'hFFFF;
            r_init   <= 1'b1;
            r_count  <= pafp_pkg::t_cnt'(1);
            r_status <= pafp_pkg::ST_OK;
            r_found  <= 1'b0;
            r_scan   <= '0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_status <= n_status;
            if (i_cfg_we) begin
                r_msize <= i_cfg_wdata;
                r_init  <= 1'b1;
            end else if (r_state == pafp_pkg::S_IDLE) begin
                r_init  <= 1'b0;
            end
            if (r_state == pafp_pkg::S_IDLE && i_start && !r_init) begin
                r_op     <= i_opcode;
                r_req    <= i_request_size;
                r_fstart <= i_free_start;
                r_scan   <= '0;
                r_found  <= 1'b0;
                r_pick   <= '0;
            end else if (r_state == pafp_pkg::S_SCAN) begin
                r_scan <= r_scan + 1'b1;
                if (w_take) begin
                    r_found <= 1'b1;
                    r_pick  <= w_sidx;
                    r_psize <= w_se.size;
                end
            end
            if (r_state == pafp_pkg::S_DECIDE) r_grant <= w_pe.start;
        end
    end

    assign o_busy  = r_state != pafp_pkg::S_IDLE || r_init;
    assign o_done  = r_state == pafp_pkg::S_DONE;
    assign o_status = r_status;
    assign o_granted_start = (r_status == pafp_pkg::ST_OK && r_op != pafp_pkg::OP_FREE)
                             ? r_grant : 16'd0;
endmodule
`default_nettype wire

// ----- sim/pafp_checker.sv -----
// Checker for the partition allocator: watches request, config and result beats,
// keeps its own partition table, and counts mismatches. Depends on pafp_pkg.
`timescale 1ns / 1ps
module pafp_checker
    import pafp_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_we,
    input  wire [15:0] i_cfg_wdata,
    input  wire        i_start,
    input  wire        i_busy,
    input  wire [1:0]  i_opcode,
    input  wire [15:0] i_request_size,
    input  wire [15:0] i_free_start,
    input  wire        i_done,
    input  wire [1:0]  i_status,
    input  wire [15:0] i_granted_start,
    output int         o_errors,
    output int         o_pending,
    output int         o_results
);
    typedef struct packed {
        t_status st;
        t_addr   gs;
    } t_grant;

    t_addr  tbl_start [MaxParts];
    t_addr  tbl_size  [MaxParts];
    logic   tbl_alloc [MaxParts];
    int     tbl_count;
    t_grant grant_q [$];

    assign o_pending = grant_q.size();

    function automatic void table_reinit(input t_addr msize);
        for (int i = 0; i < MaxParts; i++) begin
            tbl_start[i] = '0;
            tbl_size[i]  = '0;
            tbl_alloc[i] = 1'b0;
        end
        tbl_size[0] = msize;
        tbl_count   = 1;
    endfunction

    function automatic void table_drop(input int idx);
        for (int i = idx; i + 1 < tbl_count; i++) begin
            tbl_start[i] = tbl_start[i+1];
            tbl_size[i]  = tbl_size[i+1];
            tbl_alloc[i] = tbl_alloc[i+1];
        end
        tbl_count--;
    endfunction

    function automatic t_grant predict_grant(input t_op op, input t_addr req,
                                             input t_addr fstart);
        t_grant g;
        int     pick;
        int     idx;
        bit     found;
        t_addr  rem;
        g.st  = ST_OK;
        g.gs  = '0;
        pick  = 0;
        found = 0;
        if (op == OP_FREE) begin
            idx = tbl_count;
            for (int i = 0; i < tbl_count; i++)
                if (idx == tbl_count && tbl_alloc[i] && tbl_start[i] == fstart) idx = i;
            if (idx == tbl_count) begin
                g.st = ST_NOT_ALC;
                return g;
            end
            tbl_alloc[idx] = 1'b0;
            if (idx + 1 < tbl_count && !tbl_alloc[idx+1]) begin
                tbl_size[idx] = tbl_size[idx] + tbl_size[idx+1];
                table_drop(idx + 1);
            end
            if (idx > 0 && !tbl_alloc[idx-1]) begin
                tbl_size[idx-1] = tbl_size[idx-1] + tbl_size[idx];
                table_drop(idx);
            end
            return g;
        end
        if (req == 0) begin
            g.st = ST_FULL;
            return g;
        end
        for (int i = 0; i < tbl_count; i++) begin
            if (tbl_alloc[i] || tbl_size[i] < req) continue;
            if (!found) begin
                pick  = i;
                found = 1;
                if (op == OP_FIRST) break;
            end else if (op == OP_BEST && tbl_size[i] < tbl_size[pick]) begin
                pick = i;
            end else if (op == OP_WORST && tbl_size[i] > tbl_size[pick]) begin
                pick = i;
            end
        end
        if (!found) begin
            g.st = ST_NO_FIT;
            return g;
        end
        rem = tbl_size[pick] - req;
        if (rem != 0) begin
            if (tbl_count >= MaxParts) begin
                g.st = ST_FULL;
                return g;
            end
            for (int i = tbl_count; i > pick + 1; i--) begin
                tbl_start[i] = tbl_start[i-1];
                tbl_size[i]  = tbl_size[i-1];
                tbl_alloc[i] = tbl_alloc[i-1];
            end
            tbl_start[pick+1] = tbl_start[pick] + req;
            tbl_size[pick+1]  = rem;
            tbl_alloc[pick+1] = 1'b0;
            tbl_count++;
            tbl_size[pick] = req;
        end
        tbl_alloc[pick] = 1'b1;
        g.gs = tbl_start[pick];
        return g;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
        o_errors++;
    endtask

    initial begin
        o_errors  = 0;
        o_results = 0;
        table_reinit(16'hFFFF);
    end

    always @(posedge i_clk) begin
        t_grant want;
        if (!i_rst_n) begin
            table_reinit(16'hFFFF);
            grant_q.delete();
        end else begin
            if (i_done) begin
                o_results++;
                if (grant_q.size() == 0) begin
                    report_mismatch("unexpected beat", 1, 0);
                end else begin
                    want = grant_q.pop_front();
                    if (i_status !== want.st) report_mismatch("status", i_status, want.st);
                    if (i_granted_start !== want.gs)
                        report_mismatch("granted_start", i_granted_start, want.gs);
                end
            end
            if (i_cfg_we) table_reinit(i_cfg_wdata);
            if (i_start && !i_busy)
                grant_q.push_back(predict_grant(t_op'(i_opcode), i_request_size,
                                                i_free_start));
        end
    end
endmodule

// ----- sim/tb_partition_allocator_fit_policies.sv -----
// Testbench top for the partition allocator: drives requests and memory size
// writes, with pafp_checker predicting results. Depends on pafp_pkg, the RTL, checker.
`timescale 1ns / 1ps
module tb_partition_allocator_fit_policies;
    import pafp_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [15:0] i_cfg_wdata;
    logic        i_start;
    logic [1:0]  i_opcode;
    logic [15:0] i_request_size;
    logic [15:0] i_free_start;
    wire         o_busy;
    wire         o_done;
    wire  [1:0]  o_status;
    wire  [15:0] o_granted_start;
    int          errors;
    int          pending;
    int          results;
    t_addr       live_starts [$];
    t_addr       msize;
    int          beats;

    partition_allocator_fit_policies dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_start(i_start), .i_opcode(i_opcode), .i_request_size(i_request_size),
        .i_free_start(i_free_start), .o_busy(o_busy), .o_done(o_done),
        .o_status(o_status), .o_granted_start(o_granted_start)
    );

    pafp_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_start(i_start), .i_busy(o_busy), .i_opcode(i_opcode),
        .i_request_size(i_request_size), .i_free_start(i_free_start),
        .i_done(o_done), .i_status(o_status), .i_granted_start(o_granted_start),
        .o_errors(errors), .o_pending(pending), .o_results(results)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("FAILURE");
        $finish;
    end

    // grant bookkeeping for picking plausible free starts
    always @(posedge i_clk)
        if (o_done && o_status == ST_OK && o_granted_start != 0) live_starts.push_back(o_granted_start);

    task automatic send_req(input t_op op, input t_addr req, input t_addr fs);
        i_start        <= 1'b1;
        i_opcode       <= op;
        i_request_size <= req;
        i_free_start   <= fs;
        do @(posedge i_clk); while (o_busy);
        @(negedge i_clk);
        i_start <= 1'b0;
        @(negedge i_clk);
        beats++;
    endtask

    task automatic drain();
        while (pending != 0) @(negedge i_clk);
        repeat (MaxParts + 8) @(negedge i_clk);
    endtask

    task automatic write_size(input t_addr v);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        msize = v;
        live_starts.delete();
        repeat (2) @(negedge i_clk);
    endtask

    task automatic random_req();
        int    r;
        t_addr fs;
        int    k;
        r = $urandom_range(0, 99);
        if (r < 40 || live_starts.size() == 0) begin
            send_req(t_op'($urandom_range(0, 2)),
                     (r < 3) ? t_addr'($urandom) : t_addr'($urandom_range(1, msize / 6 + 1)),
                     t_addr'($urandom));
        end else if (r < 90) begin
            k  = $urandom_range(0, live_starts.size() - 1);
            fs = live_starts[k];
            live_starts.delete(k);
            send_req(OP_FREE, t_addr'($urandom), fs);
        end else begin
            send_req(OP_FREE, t_addr'($urandom), (r < 95) ? 16'd0 : t_addr'($urandom));
        end
    endtask

    initial begin
        i_rst_n = 1'b0; i_cfg_we = 1'b0; i_cfg_wdata = '0; i_start = 1'b0;
        i_opcode = '0; i_request_size = '0; i_free_start = '0;
        beats = 0; msize = 16'hFFFF;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (3) @(negedge i_clk);

        // directed: zero size, exact fit, no fit, fill table, free merges
        send_req(OP_FIRST, 16'd0, 16'd0);
        send_req(OP_FREE, 16'd0, 16'd0);
        send_req(OP_BEST, 16'hFFFF, 16'hFFFF);
        send_req(OP_FREE, 16'd0, 16'd0);
        write_size(16'd100);
        send_req(OP_WORST, 16'd101, 16'd0);
        for (int i = 0; i < 16; i++) send_req(t_op'(i % 3), 16'd5, 16'd0);
        send_req(OP_FREE, 16'd0, 16'd10);
        send_req(OP_FREE, 16'd0, 16'd5);
        send_req(OP_FREE, 16'd0, 16'd15);
        send_req(OP_BEST, 16'd3, 16'd0);
        send_req(OP_WORST, 16'd2, 16'd0);
        write_size(16'd0);
        send_req(OP_FIRST, 16'd1, 16'd0);
        write_size(16'd1);
        send_req(OP_FIRST, 16'd1, 16'd0);
        send_req(OP_FREE, 16'd0, 16'd0);

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: write_size(16'hFFFF);
                1: write_size(16'd1);
                5: write_size(16'hFFFF);
                default: write_size(t_addr'($urandom_range(2, 65535)));
            endcase
            for (int n = 0; n < 30; n++) begin
                if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 30)) @(negedge i_clk);
                repeat ($urandom_range(1, 12)) random_req();
                if (n == 15) drain();
            end
        end
        drain();
        $display("Covered %0d request beats and %0d result beats over several memory sizes,",
                 beats, results);
        $display("all three fit policies, frees with merges, and every error status.");
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule

// ----- partition_allocator_fit_policies.f -----
rtl/pafp_pkg.sv
rtl/pafp_cell.sv
rtl/partition_allocator_fit_policies.sv
sim/pafp_checker.sv
sim/tb_partition_allocator_fit_policies.sv
